/* rtl/ecdsa_der_signature_decoder_defines.svh */
// Assertion macros for the DER signature decoder.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef ECDSA_DER_SIGNATURE_DECODER_DEFINES_SVH
`define ECDSA_DER_SIGNATURE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EDSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EDSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/edsd_pkg.sv */
// Shared types and constants of the DER signature decoder.
// No dependencies; imported by the parser, the emitter and the top level.
package edsd_pkg;

   localparam int INT_BYTES_DEFAULT = 32;

   localparam logic [7:0] SEQ_TAG   = 8'h30;
   localparam logic [7:0] INT_TAG   = 8'h02;
   localparam logic [6:0] COUNT_MAX = 7'd127;

   typedef enum logic [2:0] {
      PH_SEQ_TAG,
      PH_SEQ_LEN,
      PH_INT_TAG,
      PH_INT_LEN,
      PH_INT_BODY,
      PH_DONE
   } phase_type;

   // Parser to emitter: store write strobe and end-of-signature status.
   typedef struct packed {
      logic wr_en;
      logic done;
      logic ok;
   } edsd_ctrl_type;

endpackage

/* rtl/ecdsa_der_signature_decoder.sv */
// DER-encoded ECDSA signature to raw r||s converter, top level.
// Depends on edsd_pkg, edsd_parser, edsd_emitter and the defines header.
//
// Usage: the encoding enters one byte per request on the req_ channel,
// req_final_byte marking its last byte. Every byte is parsed as it is
// accepted, so non-final bytes are taken one per cycle. When the final
// byte is accepted the verdict is fixed and the store bank holding r and s
// is handed to the read-out, which emits 2*INT_BYTES results on the rsp_
// channel, big-endian r then s, with rsp_last_raw on the last one. A
// malformed encoding gives rsp_status high and all-zero bytes.
// Read-out: accepting the final byte sets the busy register, which starts
// the reads into the result register; one result per cycle while rsp_ready
// is high, set by the single read port.
// The next signature's bytes fill the other bank during read-out; only its
// final byte is held off (req_ready low) until the read-out has issued its
// last read. A stall on rsp_ready holds the result register and the read-out.
// Reset clears the parser, the valid bits of both banks and the read-out;
// there is no clearing pass.
`include "ecdsa_der_signature_decoder_defines.svh"

module ecdsa_der_signature_decoder #(
   parameter int INT_BYTES = edsd_pkg::INT_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_raw_byte,
   output logic       rsp_status,
   output logic       rsp_last_raw
);
   import edsd_pkg::*;

   localparam int AW = $clog2(2 * INT_BYTES);

   edsd_ctrl_type ctrl;
   logic [AW-1:0] wr_idx;
   logic [7:0]    wr_data;
   logic          emit_busy;
   logic          req_accept;

   // hold a final byte back while the previous signature is still read out
   assign req_ready  = !emit_busy || !req_final_byte;
   assign req_accept = req_valid && req_ready;

   edsd_parser #(
      .INT_BYTES (INT_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .ctrl       (ctrl),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data)
   );

   edsd_emitter #(
      .INT_BYTES (INT_BYTES)
   ) u_emitter (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .wr_idx       (wr_idx),
      .wr_data      (wr_data),
      .busy         (emit_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_raw_byte (rsp_raw_byte),
      .rsp_status   (rsp_status),
      .rsp_last_raw (rsp_last_raw)
   );

   `EDSD_ASSERT_NEXT(a_final_starts_readout, req_accept && req_final_byte, emit_busy, "final byte did not start read-out")
   `EDSD_ASSERT_SAME(a_final_when_idle, req_accept && req_final_byte, !emit_busy, "final byte taken during read-out")
   `EDSD_ASSERT_SAME(a_fail_gives_zero, rsp_valid && rsp_status, rsp_raw_byte == 8'h00, "failed decode emitted data")

endmodule

/* rtl/edsd_parser.sv */
// Byte-serial DER parser: tracks phase, counts and the integer slot,
// and produces store writes and the verdict on the final byte. Uses edsd_pkg.
module edsd_parser #(
   parameter int INT_BYTES = edsd_pkg::INT_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [7:0]                      data_byte,
   input  logic                            final_byte,
   output edsd_pkg::edsd_ctrl_type         ctrl,
   output logic [$clog2(2*INT_BYTES)-1:0]  wr_idx,
   output logic [7:0]                      wr_data
);
   import edsd_pkg::*;

   localparam int RAW_BYTES = 2 * INT_BYTES;
   localparam int AW        = $clog2(RAW_BYTES);
   localparam int RW        = $clog2(INT_BYTES + 2);
   localparam int SW        = AW + RW + 1;

   phase_type      phase_ff, phase_in;
   logic [6:0]     count_ff, count_in;
   logic [6:0]     seq_len_ff, seq_len_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic           slot_ff, slot_in;
   logic           err_ff, err_in;
   logic           ok_c;
   logic           err_pre;
   logic [SW-1:0]  idx_wide;

   // Error state once the byte count has been checked.
   assign err_pre = err_ff || (count_ff == COUNT_MAX);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      seq_len_in = seq_len_ff;
      rem_in     = rem_ff;
      slot_in    = slot_ff;
      err_in     = err_ff;
      ok_c       = 1'b0;
      if (accept) begin
         if (!err_ff) begin
            if (count_ff == COUNT_MAX) begin
               err_in = 1'b1;
            end else begin
               count_in = count_ff + 7'd1;
            end
         end
         if (!err_pre) begin
            case (phase_ff)
               PH_SEQ_TAG: begin
                  if (data_byte != SEQ_TAG) err_in = 1'b1;
                  else phase_in = PH_SEQ_LEN;
               end
               PH_SEQ_LEN: begin
                  if (data_byte[7]) begin
                     err_in = 1'b1;
                  end else begin
                     seq_len_in = data_byte[6:0];
                     phase_in   = PH_INT_TAG;
                  end
               end
               PH_INT_TAG: begin
                  if (data_byte != INT_TAG) err_in = 1'b1;
                  else phase_in = PH_INT_LEN;
               end
               PH_INT_LEN: begin
                  if (data_byte == 8'd0 || data_byte > 8'(INT_BYTES + 1)) begin
                     err_in = 1'b1;
                  end else begin
                     rem_in   = RW'(data_byte);
                     phase_in = PH_INT_BODY;
                  end
               end
               PH_INT_BODY: begin
                  if (rem_ff != '0) rem_in = rem_ff - RW'(1);
                  if (rem_in == '0) begin
                     if (!slot_ff) begin
                        slot_in  = 1'b1;
                        phase_in = PH_INT_TAG;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               default: err_in = 1'b1;
            endcase
         end
         if (final_byte) begin
            ok_c = !err_in && (phase_in == PH_DONE)
                   && ({1'b0, count_in} == ({1'b0, seq_len_in} + 8'd2));
            // start over for the next signature
            phase_in   = PH_SEQ_TAG;
            count_in   = '0;
            seq_len_in = '0;
            rem_in     = '0;
            slot_in    = 1'b0;
            err_in     = 1'b0;
         end
      end
   end

   always_comb begin
      idx_wide = (slot_ff ? SW'(INT_BYTES) : SW'(0)) + SW'(INT_BYTES) - SW'(rem_ff);
      wr_idx   = idx_wide[AW-1:0];
      wr_data  = data_byte;
      ctrl.wr_en = accept && !err_pre && (phase_ff == PH_INT_BODY)
                   && (rem_ff != '0) && (rem_ff <= RW'(INT_BYTES));
      ctrl.done  = accept && final_byte;
      ctrl.ok    = ok_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEQ_TAG;
         count_ff   <= '0;
         seq_len_ff <= '0;
         rem_ff     <= '0;
         slot_ff    <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         seq_len_ff <= seq_len_in;
         rem_ff     <= rem_in;
         slot_ff    <= slot_in;
         err_ff     <= err_in;
      end
   end

endmodule

/* rtl/edsd_emitter.sv */
// Two-bank raw byte store with per-entry valid bits and the read-out
// sequencer that drives the result register. Uses edsd_pkg.
module edsd_emitter #(
   parameter int INT_BYTES = edsd_pkg::INT_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  edsd_pkg::edsd_ctrl_type         ctrl,
   input  logic [$clog2(2*INT_BYTES)-1:0]  wr_idx,
   input  logic [7:0]                      wr_data,
   output logic                            busy,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_raw_byte,
   output logic                            rsp_status,
   output logic                            rsp_last_raw
);
   import edsd_pkg::*;

   localparam int RAW_BYTES = 2 * INT_BYTES;
   localparam int AW        = $clog2(RAW_BYTES);
   localparam int DEPTH     = 2 << AW;

   logic [7:0]           raw_mem [DEPTH];
   logic [RAW_BYTES-1:0] valid_ff [2];
   logic [RAW_BYTES-1:0] valid_in [2];

   logic          wbank_ff, wbank_in;
   logic          rbank_ff, rbank_in;
   logic          busy_ff, busy_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic          ok_ff, ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          status_ff, last_ff, keep_ff;
   logic [7:0]    rd_data_ff;
   logic          advance, issue;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign issue   = advance && busy_ff;

   always_comb begin
      wbank_in     = wbank_ff;
      rbank_in     = rbank_ff;
      busy_in      = busy_ff;
      ridx_in      = ridx_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      if (advance) rsp_valid_in = busy_ff;
      if (issue) begin
         ridx_in = ridx_ff + AW'(1);
         if (ridx_ff == AW'(RAW_BYTES - 1)) busy_in = 1'b0;
      end
      if (ctrl.wr_en) valid_in[wbank_ff][wr_idx] = 1'b1;
      // hand the filled bank to the read-out, clear the other for filling
      if (ctrl.done) begin
         busy_in            = 1'b1;
         ridx_in            = '0;
         rbank_in           = wbank_ff;
         ok_in              = ctrl.ok;
         wbank_in           = ~wbank_ff;
         valid_in[~wbank_ff] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbank_ff     <= 1'b0;
         rbank_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         ridx_ff      <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff[0]  <= '0;
         valid_ff[1]  <= '0;
      end else begin
         wbank_ff     <= wbank_in;
         rbank_ff     <= rbank_in;
         busy_ff      <= busy_in;
         ridx_ff      <= ridx_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) raw_mem[{wbank_ff, wr_idx}] <= wr_data;
   end

   // Result payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= raw_mem[{rbank_ff, ridx_ff}];
         keep_ff    <= ok_ff && valid_ff[rbank_ff][ridx_ff];
         status_ff  <= !ok_ff;
         last_ff    <= (ridx_ff == AW'(RAW_BYTES - 1));
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_raw_byte = keep_ff ? rd_data_ff : 8'h00;
   assign rsp_status   = status_ff;
   assign rsp_last_raw = last_ff;

endmodule

/* dv/ecdsa_der_signature_decoder_tb.sv */
// Self-checking testbench for the DER ECDSA signature decoder.
// Depends on edsd_pkg and ecdsa_der_signature_decoder; a built-in decoder model
// predicts the 64 raw r||s bytes and the status of every encoding.
module ecdsa_der_signature_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import edsd_pkg::*;

   localparam int SLOT_BYTES  = INT_BYTES_DEFAULT;
   localparam int RAW_COUNT   = 2 * SLOT_BYTES;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_BYTES = 40;

   typedef struct packed {
      logic [7:0] raw;
      logic       status;
      logic       is_last;
   } raw_result_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_raw_byte;
   logic       rsp_status;
   logic       rsp_last_raw;

   // decoder model state
   phase_type  dec_phase;
   int         dec_count;
   int         dec_seq_len;
   int         dec_int_left;
   int         dec_slot;
   bit         dec_error;
   logic [7:0] dec_store [RAW_COUNT];

   raw_result_type expected_raw [$];
   logic [7:0]  enc [$];
   int          sent_bytes   = 0;
   int          mismatches   = 0;
   bit          idling_on    = 1'b1;
   int          hold_req     = 0;
   int          hold_seen    = 0;
   int          hold_left    = 0;
   int          rx_gap       = 0;
   int          stalled      = 0;

   ecdsa_der_signature_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_raw_byte   (rsp_raw_byte),
      .rsp_status     (rsp_status),
      .rsp_last_raw   (rsp_last_raw)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_decoder();
      dec_phase    = PH_SEQ_TAG;
      dec_count    = 0;
      dec_seq_len  = 0;
      dec_int_left = 0;
      dec_slot     = 0;
      dec_error    = 1'b0;
      foreach (dec_store[i]) dec_store[i] = 8'h00;
   endfunction

   // Advance the decoder model by one accepted request; queue the raw bytes on the final one.
   function automatic void decode_byte(logic [7:0] b, logic fin);
      raw_result_type item;
      bit ok;
      sent_bytes++;
      if (!dec_error) begin
         if (dec_count >= int'(COUNT_MAX)) dec_error = 1'b1;
         else dec_count++;
      end
      if (!dec_error) begin
         case (dec_phase)
            PH_SEQ_TAG: begin
               if (b != SEQ_TAG) dec_error = 1'b1;
               else dec_phase = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
               if (b[7]) dec_error = 1'b1;
               else begin
                  dec_seq_len = b;
                  dec_phase   = PH_INT_TAG;
               end
            end
            PH_INT_TAG: begin
               if (b != INT_TAG) dec_error = 1'b1;
               else dec_phase = PH_INT_LEN;
            end
            PH_INT_LEN: begin
               if (b == 8'd0 || int'(b) > SLOT_BYTES + 1) dec_error = 1'b1;
               else begin
                  dec_int_left = b;
                  dec_phase    = PH_INT_BODY;
               end
            end
            PH_INT_BODY: begin
               // the leading byte of an oversized integer is dropped unchecked
               if (dec_int_left <= SLOT_BYTES && dec_int_left > 0)
                  dec_store[dec_slot * SLOT_BYTES + SLOT_BYTES - dec_int_left] = b;
               if (dec_int_left > 0) dec_int_left--;
               if (dec_int_left == 0) begin
                  if (dec_slot == 0) begin
                     dec_slot  = 1;
                     dec_phase = PH_INT_TAG;
                  end else begin
                     dec_phase = PH_DONE;
                  end
               end
            end
            default: dec_error = 1'b1;
         endcase
      end
      if (fin) begin
         ok = !dec_error && dec_phase == PH_DONE && dec_count == dec_seq_len + 2;
         for (int k = 0; k < RAW_COUNT; k++) begin
            item.raw     = ok ? dec_store[k] : 8'h00;
            item.status  = !ok;
            item.is_last = (k == RAW_COUNT - 1);
            expected_raw.push_back(item);
         end
         clear_decoder();
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      raw_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_raw.size() == 0) begin
            report_mismatch("unexpected raw byte", rsp_raw_byte, 0);
         end else begin
            want = expected_raw.pop_front();
            if (rsp_raw_byte !== want.raw)
               report_mismatch("raw_byte", rsp_raw_byte, want.raw);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_last_raw !== want.is_last)
               report_mismatch("last_raw", rsp_last_raw, want.is_last);
         end
      end
   end

   // Result side: random gaps after each result, plus a long hold-off on request.
   always @(posedge clock) begin : receiver
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_gap    <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_ready && rsp_valid) begin
         n = idling_on ? $urandom_range(0, 3) : 0;
         rx_gap    <= n;
         rsp_ready <= (n == 0);
      end else if (!rsp_ready) begin
         if (rx_gap > 1) begin
            rx_gap <= rx_gap - 1;
         end else begin
            rx_gap    <= 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled <= 0;
      end else begin
         stalled <= stalled + 1;
         if (stalled >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("ecdsa_der_signature_decoder regression: fail");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = idling_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, fin);
   endtask

   task automatic send_encoding();
      for (int i = 0; i < enc.size(); i++)
         send_byte(enc[i], i == enc.size() - 1);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_raw.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_int_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 4);
      if (r == 6) return SLOT_BYTES;
      if (r == 7) return SLOT_BYTES + 1;
      return $urandom_range(1, SLOT_BYTES + 1);
   endfunction

   function automatic void build_signature(int r_len, int s_len);
      enc.delete();
      enc.push_back(SEQ_TAG);
      enc.push_back(8'(r_len + s_len + 4));
      enc.push_back(INT_TAG);
      enc.push_back(8'(r_len));
      repeat (r_len) enc.push_back(8'($urandom_range(0, 255)));
      enc.push_back(INT_TAG);
      enc.push_back(8'(s_len));
      repeat (s_len) enc.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic test_well_formed();
      enc = '{SEQ_TAG, 8'h06, INT_TAG, 8'h01, 8'hFF, INT_TAG, 8'h01, 8'h00};
      send_encoding();
   endtask

   task automatic test_wrong_tags();
      enc = '{8'h00};
      send_encoding();
      enc = '{SEQ_TAG, 8'h00, 8'h03};
      send_encoding();
   endtask

   task automatic test_long_form_length();
      enc = '{SEQ_TAG, 8'h80};
      send_encoding();
   endtask

   task automatic test_integer_length_bounds();
      enc = '{SEQ_TAG, 8'h02, INT_TAG, 8'h00};
      send_encoding();
      enc = '{SEQ_TAG, 8'h02, INT_TAG, 8'h22};
      send_encoding();
   endtask

   task automatic test_extra_byte();
      enc = '{SEQ_TAG, 8'h07, INT_TAG, 8'h01, 8'h5A, INT_TAG, 8'h01, 8'hA5, 8'h3C};
      send_encoding();
   endtask

   task automatic test_early_final();
      enc = '{SEQ_TAG, 8'h06, INT_TAG, 8'h01, 8'h81};
      send_encoding();
   endtask

   task automatic test_length_mismatch();
      enc = '{SEQ_TAG, 8'h05, INT_TAG, 8'h01, 8'h7E, INT_TAG, 8'h01, 8'h01};
      send_encoding();
   endtask

   // Random bytes after a maximal sequence length; the encoding ends far short of it, so the decode fails.
   task automatic test_long_stream();
      enc.delete();
      enc.push_back(SEQ_TAG);
      enc.push_back(8'h7F);
      repeat (8) enc.push_back(8'($urandom_range(0, 255)));
      send_encoding();
      wait_for_results();
   endtask

   // Hold the result side off while two signatures are offered back to back.
   task automatic test_output_stall();
      idling_on <= 1'b0;
      hold_req  <= hold_req + 1;
      build_signature(SLOT_BYTES + 1, 3);
      send_encoding();
      build_signature(2, 1);
      send_encoding();
      wait_for_results();
      idling_on <= 1'b1;
   endtask

   task automatic test_pause_until_drained();
      build_signature(1, 3);
      send_encoding();
      wait_for_results();
      build_signature(4, 2);
      send_encoding();
      wait_for_results();
   endtask

   task automatic test_random_signatures();
      int start;
      int mode;
      int n;
      start = sent_bytes;
      while (sent_bytes - start < RANDOM_BYTES) begin
         idling_on <= ($urandom_range(0, 3) != 0);
         build_signature(pick_int_len(), pick_int_len());
         mode = $urandom_range(0, 11);
         case (mode)
            0: enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
               n = $urandom_range(1, enc.size());
               while (enc.size() > n) void'(enc.pop_back());
            end
            2: enc.push_back(8'($urandom_range(0, 255)));
            3: enc[1] = $urandom_range(0, 1) ? enc[1] + 8'd1 : enc[1] - 8'd1;
            4: begin
               enc.delete();
               n = $urandom_range(1, 6);
               repeat (n) enc.push_back(8'($urandom_range(0, 255)));
            end
            5: enc[3] = $urandom_range(0, 1) ? 8'(SLOT_BYTES + 2) : 8'h00;
            default: ;
         endcase
         send_encoding();
         if ($urandom_range(0, 7) == 0) wait_for_results();
      end
   endtask

   initial begin
      clear_decoder();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_well_formed();
      test_wrong_tags();
      test_long_form_length();
      test_integer_length_bounds();
      test_extra_byte();
      test_early_final();
      test_length_mismatch();
      wait_for_results();
      test_long_stream();
      test_output_stall();
      test_pause_until_drained();
      test_random_signatures();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("ecdsa_der_signature_decoder regression: pass");
      else
         $display("ecdsa_der_signature_decoder regression: fail");
      $finish;
   end

endmodule
